>>> rtl/core/assert_macros.svh
// Assertion helpers used by the checker file lpbm_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("check failed");
`define CHK_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("check failed");
`endif

>>> rtl/core/lpbm_pkg.sv
package lpbm_pkg;
    localparam int FRAMES = 16;
    localparam int PAGE_BITS = 20;
    localparam int FW = $clog2(FRAMES);
    localparam int CW = $clog2(FRAMES + 1);

    localparam logic [2:0] OP_FIX_RD = 3'd0;
    localparam logic [2:0] OP_FIX_WR = 3'd1;
    localparam logic [2:0] OP_SET_DIRTY = 3'd2;
    localparam logic [2:0] OP_CLR_DIRTY = 3'd3;
    localparam logic [2:0] OP_FLUSH = 3'd4;

    typedef struct packed {
        logic load;
        logic fix;
        logic dirty_op;
        logic flush_step;
        logic emit_idle;
    } t_cmd;

    typedef struct packed {
        logic flush_more;
    } t_stat;
endpackage

>>> rtl/core/lpbm_ctrl.sv
module lpbm_ctrl
    import lpbm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [2:0] i_operation,
    input  t_stat      i_stat,
    output t_cmd       o_cmd,
    output logic       o_busy
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0] r_state, n_state;
    logic [2:0] r_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (r_state == S_IDLE && i_start) r_op <= i_operation;
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_busy = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state = (i_operation == OP_FLUSH) ? S_FLUSH : S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_op == OP_FIX_RD || r_op == OP_FIX_WR) o_cmd.fix = 1'b1;
                else if (r_op == OP_SET_DIRTY || r_op == OP_CLR_DIRTY) o_cmd.dirty_op = 1'b1;
                else o_cmd.emit_idle = 1'b1;
                n_state = S_IDLE;
            end
            S_FLUSH: begin
                o_cmd.flush_step = 1'b1;
                if (!i_stat.flush_more) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

>>> rtl/core/lpbm_dp.sv
module lpbm_dp
    import lpbm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  logic [2:0]           i_operation,
    input  logic [19:0]          i_page,
    input  logic [3:0]           i_frame,
    output t_stat                o_stat,
    output logic                 o_valid,
    output logic [3:0]           o_frame_out,
    output logic                 o_hit,
    output logic                 o_load_needed,
    output logic                 o_writeback_valid,
    output logic [19:0]          o_writeback_page,
    output logic [3:0]           o_writeback_frame,
    output logic                 o_status,
    output logic [31:0]          o_hit_total,
    output logic [4:0]           o_free_frames,
    output logic                 o_last
);
    logic [PAGE_BITS-1:0] r_fpage [FRAMES];
    logic [FW-1:0]        r_rank [FRAMES];
    logic [FRAMES-1:0]    r_vld, r_dirty;
    logic [CW-1:0]        r_filled;
    logic [31:0]          r_hits;
    logic [2:0]           r_op;
    logic [PAGE_BITS-1:0] r_page;
    logic [3:0]           r_fr;

    logic [PAGE_BITS-1:0] n_fpage [FRAMES];
    logic [FW-1:0]        n_rank [FRAMES];
    logic [FRAMES-1:0]    n_vld, n_dirty;
    logic [CW-1:0]        n_filled;
    logic [31:0]          n_hits;
    logic [2:0]           n_op;
    logic [PAGE_BITS-1:0] n_page;
    logic [3:0]           n_fr;

    logic                 r_valid, n_valid;
    logic [3:0]           r_frame_out, n_frame_out;
    logic                 r_hit, n_hit;
    logic                 r_load, n_load;
    logic                 r_wb_valid, n_wb_valid;
    logic [19:0]          r_wb_page, n_wb_page;
    logic [3:0]           r_wb_frame, n_wb_frame;
    logic                 r_status, n_status;
    logic [31:0]          r_hit_total, n_hit_total;
    logic [4:0]           r_free, n_free;
    logic                 r_last, n_last;

    logic [FRAMES-1:0] match, lru0, fdirty, fd_low, fd_rest;
    logic              any_hit;
    logic [FW-1:0]     hit_idx, lru_idx, fl_idx, tgt, old_rank;
    logic              fr_ok;

    always_comb begin
        fdirty = r_vld & r_dirty;
        fd_low = fdirty & (~fdirty + 1'b1);
        fd_rest = fdirty & ~fd_low;
        match = '0;
        lru0 = '0;
        hit_idx = '0;
        lru_idx = '0;
        fl_idx = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            match[i] = r_vld[i] && (r_fpage[i] == r_page);
            lru0[i] = (r_rank[i] == '0);
            if (match[i]) hit_idx = FW'(i);
            if (lru0[i]) lru_idx = FW'(i);
            if (fdirty[i]) fl_idx = FW'(i);
        end
        any_hit = |match;
        tgt = any_hit ? hit_idx : lru_idx;
        old_rank = r_rank[tgt];
        fr_ok = ({1'b0, r_fr} < (FW+1)'(FRAMES)) && r_vld[FW'(r_fr)];
    end

    assign o_stat.flush_more = |fd_rest;

    always_comb begin
        n_fpage = r_fpage;
        n_rank = r_rank;
        n_vld = r_vld;
        n_dirty = r_dirty;
        n_filled = r_filled;
        n_hits = r_hits;
        n_op = r_op;
        n_page = r_page;
        n_fr = r_fr;
        n_valid = 1'b0;
        n_frame_out = '0;
        n_hit = 1'b0;
        n_load = 1'b0;
        n_wb_valid = 1'b0;
        n_wb_page = '0;
        n_wb_frame = '0;
        n_status = 1'b0;
        n_last = 1'b1;
        if (i_cmd.load) begin
            n_op = i_operation;
            n_page = PAGE_BITS'(i_page);
            n_fr = i_frame;
        end
        if (i_cmd.fix) begin
            n_valid = 1'b1;
            if (any_hit) begin
                if (r_hits != '1) n_hits = r_hits + 32'd1;
                for (int i = 0; i < FRAMES; i++)
                    if (r_vld[i] && FW'(i) != tgt && r_rank[i] > old_rank)
                        n_rank[i] = r_rank[i] - 1'b1;
                n_rank[tgt] = FW'(r_filled - 1'b1);
                if (r_op == OP_FIX_WR) n_dirty[tgt] = 1'b1;
                n_frame_out = 4'(tgt);
                n_hit = 1'b1;
            end else if (r_filled < CW'(FRAMES)) begin
                n_vld[FW'(r_filled)] = 1'b1;
                n_fpage[FW'(r_filled)] = r_page;
                n_dirty[FW'(r_filled)] = (r_op == OP_FIX_WR);
                n_rank[FW'(r_filled)] = FW'(r_filled);
                n_filled = r_filled + 1'b1;
                n_frame_out = 4'(r_filled);
                n_load = (r_op == OP_FIX_RD);
            end else begin
                for (int i = 0; i < FRAMES; i++)
                    if (r_vld[i] && FW'(i) != tgt && r_rank[i] > old_rank)
                        n_rank[i] = r_rank[i] - 1'b1;
                n_rank[tgt] = FW'(r_filled - 1'b1);
                n_fpage[tgt] = r_page;
                n_dirty[tgt] = (r_op == OP_FIX_WR);
                n_frame_out = 4'(tgt);
                n_load = (r_op == OP_FIX_RD);
                if (r_dirty[tgt]) begin
                    n_wb_valid = 1'b1;
                    n_wb_page = 20'(r_fpage[tgt]);
                    n_wb_frame = 4'(tgt);
                end
            end
        end
        if (i_cmd.dirty_op) begin
            n_valid = 1'b1;
            if (fr_ok) n_dirty[FW'(r_fr)] = (r_op == OP_SET_DIRTY);
            else n_status = 1'b1;
        end
        if (i_cmd.emit_idle) n_valid = 1'b1;
        if (i_cmd.flush_step) begin
            n_valid = 1'b1;
            if (|fdirty) begin
                n_dirty[fl_idx] = 1'b0;
                n_wb_valid = 1'b1;
                n_wb_page = 20'(r_fpage[fl_idx]);
                n_wb_frame = 4'(fl_idx);
                n_last = ~|fd_rest;
            end
        end
        n_hit_total = n_hits;
        n_free = 5'(CW'(FRAMES) - n_filled);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_dirty <= '0;
            r_filled <= '0;
            r_hits <= '0;
            r_valid <= 1'b0;
        end else begin
            r_vld <= n_vld;
            r_dirty <= n_dirty;
            r_filled <= n_filled;
            r_hits <= n_hits;
            r_valid <= n_valid;
        end
        r_fpage <= n_fpage;
        r_rank <= n_rank;
        r_op <= n_op;
        r_page <= n_page;
        r_fr <= n_fr;
        r_frame_out <= n_frame_out;
        r_hit <= n_hit;
        r_load <= n_load;
        r_wb_valid <= n_wb_valid;
        r_wb_page <= n_wb_page;
        r_wb_frame <= n_wb_frame;
        r_status <= n_status;
        r_hit_total <= n_hit_total;
        r_free <= n_free;
        r_last <= n_last;
    end

    assign o_valid = r_valid;
    assign o_frame_out = r_frame_out;
    assign o_hit = r_hit;
    assign o_load_needed = r_load;
    assign o_writeback_valid = r_wb_valid;
    assign o_writeback_page = r_wb_page;
    assign o_writeback_frame = r_wb_frame;
    assign o_status = r_status;
    assign o_hit_total = r_hit_total;
    assign o_free_frames = r_free;
    assign o_last = r_last;
endmodule

>>> rtl/core/lru_page_buffer_manager.sv
// LRU page buffer manager: fully associative page-to-frame map.
// Issue a request by raising start with i_operation, i_page and i_frame;
// it transfers at a clock edge where busy is low.
// Operations: fix for read or write, set or clear dirty by frame, flush.
// Results appear for one cycle each, marked by o_valid; o_last marks the
// final result of a request. The receiver cannot stall the block.
// Fix, dirty and unused codes give one result, and busy stays high until
// the block is back in idle, so no new request is taken before then.
// Flush gives one result per dirty frame (one cycle each, ascending
// frame order), or one result when none is dirty; busy stays high until its final step.
// The match and LRU rank update of a fix are one combinational
// read-modify step over all frame registers.
// Reset clears valid and dirty bits, the fill count and the hit counter
// at once; no clearing pass is needed.
module lru_page_buffer_manager
    import lpbm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_operation,
    input  logic [19:0] i_page,
    input  logic [3:0]  i_frame,
    output logic        o_valid,
    output logic [3:0]  o_frame_out,
    output logic        o_hit,
    output logic        o_load_needed,
    output logic        o_writeback_valid,
    output logic [19:0] o_writeback_page,
    output logic [3:0]  o_writeback_frame,
    output logic        o_status,
    output logic [31:0] o_hit_total,
    output logic [4:0]  o_free_frames,
    output logic        o_last
);
    t_cmd  cmd;
    t_stat stat;

    lpbm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_operation(i_operation), .i_stat(stat), .o_cmd(cmd), .o_busy(busy)
    );

    lpbm_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_operation(i_operation), .i_page(i_page), .i_frame(i_frame),
        .o_stat(stat), .o_valid(o_valid), .o_frame_out(o_frame_out),
        .o_hit(o_hit), .o_load_needed(o_load_needed),
        .o_writeback_valid(o_writeback_valid),
        .o_writeback_page(o_writeback_page),
        .o_writeback_frame(o_writeback_frame), .o_status(o_status),
        .o_hit_total(o_hit_total), .o_free_frames(o_free_frames),
        .o_last(o_last)
    );
endmodule

>>> rtl/core/lpbm_checker.sv
`include "assert_macros.svh"
module lpbm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic        o_hit,
    input logic        o_load_needed,
    input logic        o_writeback_valid,
    input logic        o_last,
    input logic [31:0] o_hit_total
);
    `CHK_NEXT(a_busy_after_start, i_clk, i_rst_n, start && !busy, busy)
    `CHK_IMPL(a_hit_no_load, i_clk, i_rst_n, o_valid && o_hit, !o_load_needed)
    `CHK_IMPL(a_hit_no_wb, i_clk, i_rst_n, o_valid && o_hit, !o_writeback_valid)
    `CHK_NEXT(a_hits_mono, i_clk, i_rst_n, o_valid, !o_valid || o_hit_total >= $past(o_hit_total))
    `CHK_IMPL(a_idle_last, i_clk, i_rst_n, o_valid && !busy, o_last)
endmodule

bind lru_page_buffer_manager lpbm_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_hit(o_hit), .o_load_needed(o_load_needed),
    .o_writeback_valid(o_writeback_valid), .o_last(o_last),
    .o_hit_total(o_hit_total)
);

>>> sim/testbench.sv
module testbench;
    import lpbm_pkg::*;

    typedef struct packed {
        logic [3:0]  frame_out;
        logic        hit;
        logic        load_needed;
        logic        wb_valid;
        logic [19:0] wb_page;
        logic [3:0]  wb_frame;
        logic        status;
        logic [31:0] hit_total;
        logic [4:0]  free_frames;
        logic        last;
    } t_result;

    class page_map_scoreboard;
        logic [19:0] page_of[16];
        bit          valid_of[16];
        bit          dirty_of[16];
        int          rank_of[16];
        int          filled;
        logic [31:0] hits;
        t_result     pending[$];
        int          errors;

        function new();
            filled = 0;
            hits = '0;
            errors = 0;
            for (int i = 0; i < 16; i++) begin
                valid_of[i] = 1'b0;
                dirty_of[i] = 1'b0;
                rank_of[i] = 0;
            end
        endfunction

        function t_result blank();
            t_result r;
            r = '0;
            r.hit_total = hits;
            r.free_frames = 5'(16 - filled);
            r.last = 1'b1;
            return r;
        endfunction

        function void promote(int f);
            int r;
            r = rank_of[f];
            for (int i = 0; i < 16; i++)
                if (valid_of[i] && i != f && rank_of[i] > r) rank_of[i]--;
            rank_of[f] = filled - 1;
        endfunction

        function void note_request(logic [2:0] op, logic [19:0] pg, logic [3:0] fr);
            t_result r;
            int v;
            int n;
            if (op == OP_FIX_RD || op == OP_FIX_WR) begin
                for (int i = 0; i < 16; i++) begin
                    if (valid_of[i] && page_of[i] == pg) begin
                        if (hits != 32'hFFFF_FFFF) hits++;
                        promote(i);
                        if (op == OP_FIX_WR) dirty_of[i] = 1'b1;
                        r = blank();
                        r.frame_out = 4'(i);
                        r.hit = 1'b1;
                        pending.push_back(r);
                        return;
                    end
                end
                if (filled < 16) begin
                    v = filled;
                    valid_of[v] = 1'b1;
                    page_of[v] = pg;
                    dirty_of[v] = (op == OP_FIX_WR);
                    rank_of[v] = v;
                    filled++;
                    r = blank();
                end else begin
                    v = 0;
                    for (int i = 15; i >= 0; i--) if (rank_of[i] == 0) v = i;
                    r = blank();
                    if (dirty_of[v]) begin
                        r.wb_valid = 1'b1;
                        r.wb_page = page_of[v];
                        r.wb_frame = 4'(v);
                    end
                    promote(v);
                    page_of[v] = pg;
                    dirty_of[v] = (op == OP_FIX_WR);
                end
                r.frame_out = 4'(v);
                r.load_needed = (op == OP_FIX_RD);
                pending.push_back(r);
            end else if (op == OP_SET_DIRTY || op == OP_CLR_DIRTY) begin
                r = blank();
                if (!valid_of[fr]) r.status = 1'b1;
                else dirty_of[fr] = (op == OP_SET_DIRTY);
                pending.push_back(r);
            end else if (op == OP_FLUSH) begin
                n = 0;
                for (int i = 0; i < 16; i++) begin
                    if (valid_of[i] && dirty_of[i]) begin
                        dirty_of[i] = 1'b0;
                        r = blank();
                        r.wb_valid = 1'b1;
                        r.wb_page = page_of[i];
                        r.wb_frame = 4'(i);
                        r.last = 1'b0;
                        pending.push_back(r);
                        n++;
                    end
                end
                if (n == 0) pending.push_back(blank());
                else pending[pending.size() - 1].last = 1'b1;
            end else begin
                pending.push_back(blank());
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %h actual %h", want, got);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_operation;
    logic [19:0] i_page;
    logic [3:0]  i_frame;
    logic        o_valid;
    t_result     got;

    page_map_scoreboard sb;
    logic [19:0] page_pool[8];

    lru_page_buffer_manager dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_operation(i_operation), .i_page(i_page), .i_frame(i_frame),
        .o_valid(o_valid), .o_frame_out(got.frame_out), .o_hit(got.hit),
        .o_load_needed(got.load_needed), .o_writeback_valid(got.wb_valid),
        .o_writeback_page(got.wb_page), .o_writeback_frame(got.wb_frame),
        .o_status(got.status), .o_hit_total(got.hit_total),
        .o_free_frames(got.free_frames), .o_last(got.last)
    );

    always begin
        i_clk = 1;
        #2;
        i_clk = 0;
        #2;
    end

    always @(posedge i_clk)
        if (i_rst_n && o_valid) sb.check_result(got);

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if (n > 0) begin
            start <= 1'b0;
            i_operation <= 3'($urandom);
            i_page <= 20'($urandom);
            i_frame <= 4'($urandom);
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send(logic [2:0] op, logic [19:0] pg, logic [3:0] fr);
        start <= 1'b1;
        i_operation <= op;
        i_page <= pg;
        i_frame <= fr;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_request(op, pg, fr);
    endtask

    task automatic send_random();
        int k;
        logic [2:0] op;
        k = $urandom_range(0, 99);
        if (k < 70) op = 3'($urandom_range(0, 1));
        else if (k < 85) op = 3'($urandom_range(2, 3));
        else if (k < 95) op = OP_FLUSH;
        else op = 3'($urandom_range(5, 7));
        send(op, ($urandom_range(0, 2) == 0) ? 20'($urandom)
                                             : page_pool[$urandom_range(0, 7)],
             4'($urandom));
    endtask

    initial begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int wait_cycles;
        sb = new();
        i_rst_n = 1'b0;
        start = 1'b0;
        i_operation = '0;
        i_page = '0;
        i_frame = '0;
        for (int i = 0; i < 8; i++) page_pool[i] = 20'($urandom);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(OP_SET_DIRTY, 20'd0, 4'd0);
        send(OP_CLR_DIRTY, 20'd0, 4'd15);
        send(OP_FLUSH, 20'd0, 4'd0);
        send(3'd5, 20'hFFFFF, 4'hF);
        send(3'd7, 20'd0, 4'd0);
        send(OP_FIX_RD, 20'h00000, 4'd0);
        send(OP_FIX_WR, 20'hFFFFF, 4'd0);
        send(OP_FIX_RD, 20'h00000, 4'd0);
        send(OP_FIX_WR, 20'h00000, 4'd0);
        send(OP_SET_DIRTY, 20'd0, 4'd1);
        send(OP_CLR_DIRTY, 20'd0, 4'd1);
        send(OP_SET_DIRTY, 20'd0, 4'd15);
        for (int i = 0; i < 16; i++) send(3'(i & 1), 20'h10000 + 20'(i), 4'd0);
        send(OP_FLUSH, 20'd0, 4'd0);
        send(OP_FLUSH, 20'd0, 4'd0);

        for (int i = 0; i < 140; i++) begin
            if (i % 40 == 0)
                for (int j = 0; j < 8; j++) page_pool[j] = 20'($urandom);
            if ($urandom_range(0, 3) != 0) idle_gap();
            send_random();
        end
        start <= 1'b0;

        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 10000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
